// ===== src/chs_pkg.sv =====
// Shared constants for the chained hash set.
// No dependencies; imported by chs_bucket_hash and chained_hash_set_top.
package chs_pkg;

    localparam int KEY_W = 32;
    localparam int SUM_W = KEY_W + 1;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

endpackage

// ===== src/chs_bucket_hash.sv =====
// Bucket index unit: (HASH_OFFSET + key) mod BUCKETS.
// Power-of-two bucket counts use a registered mask of the sum; others use a
// restoring remainder, four bits per cycle. Depends on chs_pkg.
module chs_bucket_hash
    import chs_pkg::*;
#(
    parameter int BUCKETS     = 4096,
    parameter int HASH_OFFSET = 5381,
    parameter int BW          = (BUCKETS > 2) ? $clog2(BUCKETS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [KEY_W-1:0] i_key,
    output logic             o_done,
    output logic [BW-1:0]    o_bucket
);

    localparam bit IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;
    localparam int DIGIT   = 4;
    localparam int STEPS   = (SUM_W + DIGIT - 1) / DIGIT;
    localparam int PAD_W   = STEPS * DIGIT;
    localparam int CNT_W   = $clog2(STEPS + 1);

    logic [SUM_W-1:0] w_sum;

    assign w_sum = {1'b0, i_key} + SUM_W'(HASH_OFFSET);

    if (IS_POW2) begin : g_mask
        logic          r_done;
        logic [BW-1:0] r_bucket;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_done <= 1'b0;
            end else begin
                r_done <= i_start;
            end
            if (i_start) begin
                r_bucket <= w_sum[BW-1:0];
            end
        end

        assign o_done   = r_done;
        assign o_bucket = r_bucket;
    end else begin : g_rem
        localparam logic [BW:0] MODV = (BW + 1)'(BUCKETS);

        logic             r_run;
        logic             r_done;
        logic [CNT_W-1:0] r_cnt;
        logic [PAD_W-1:0] r_sum;
        logic [BW-1:0]    r_rem;
        logic [BW-1:0]    n_rem;

        always_comb begin
            logic [BW:0]   tmp;
            logic [BW-1:0] acc;
            acc = r_rem;
            for (int i = 0; i < DIGIT; i++) begin
                tmp = {acc, r_sum[PAD_W-1-i]};
                if (tmp >= MODV) begin
                    tmp = tmp - MODV;
                end
                acc = tmp[BW-1:0];
            end
            n_rem = acc;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_run  <= 1'b0;
                r_done <= 1'b0;
                r_cnt  <= '0;
            end else begin
                r_done <= 1'b0;
                if (i_start) begin
                    r_run <= 1'b1;
                    r_cnt <= CNT_W'(STEPS);
                end else if (r_run) begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_run  <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
            if (i_start) begin
                r_sum <= PAD_W'(w_sum);
                r_rem <= '0;
            end else if (r_run) begin
                r_sum <= r_sum << DIGIT;
                r_rem <= n_rem;
            end
        end

        assign o_done   = r_done;
        assign o_bucket = r_rem;
    end

endmodule

// ===== src/chained_hash_set_top.sv =====
// Top level of the chained hash set: bucket head memory, node pool memory
// and the insert / lookup sequencer. Depends on chs_pkg and chs_bucket_hash.
//
// An item is taken when start is high and busy is low; its single result
// appears on o_found / o_pool_full with o_done, which is high for a single
// cycle, and cannot be held off. With a power-of-two BUCKETS the hash is a
// registered mask; otherwise it is one load, then a restoring remainder,
// four bits per cycle. After the hash, S_HEAD reads the bucket head and
// S_DECIDE decides; a lookup with a valid head then walks the chain in
// S_WALK, each entry one read of the pool memory. After reset the bucket
// head memory is cleared one entry per cycle, with busy high.
module chained_hash_set_top
    import chs_pkg::*;
#(
    parameter int BUCKETS     = 4096,
    parameter int POOL_DEPTH  = 8192,
    parameter int HASH_OFFSET = 5381
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  logic             i_kind,
    input  logic [KEY_W-1:0] i_key,
    output logic             busy,
    output logic             o_done,
    output logic             o_found,
    output logic             o_pool_full
);

    localparam int BW   = (BUCKETS > 2) ? $clog2(BUCKETS) : 1;
    localparam int PW   = (POOL_DEPTH > 2) ? $clog2(POOL_DEPTH) : 1;
    localparam int AW   = $clog2(POOL_DEPTH + 1);
    localparam int HE_W = PW + 1;
    localparam int PE_W = KEY_W + HE_W;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_HASH   = 3'd2;
    localparam logic [2:0] S_HEAD   = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_WALK   = 3'd5;

    logic [2:0]       r_state;
    logic [BW-1:0]    r_clr;
    logic [AW-1:0]    r_alloc;
    logic             r_kind;
    logic [KEY_W-1:0] r_key;
    logic [BW-1:0]    r_bucket;
    logic             r_done;
    logic             r_found;
    logic             r_pool_full;

    logic [HE_W-1:0]  head_mem [BUCKETS];
    logic [PE_W-1:0]  pool_mem [POOL_DEPTH];
    logic [HE_W-1:0]  r_head_rd;
    logic [PE_W-1:0]  r_pool_rd;

    logic             w_accept;
    logic             w_hash_done;
    logic [BW-1:0]    w_hash_bucket;
    logic             w_head_we;
    logic [BW-1:0]    w_head_wa;
    logic [HE_W-1:0]  w_head_wd;
    logic             w_pool_we;
    logic [PW-1:0]    w_pool_ra;
    logic             w_full;
    logic             w_match;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_full   = (r_alloc == AW'(POOL_DEPTH));
    assign w_match  = (r_pool_rd[PE_W-1 -: KEY_W] == r_key);

    chs_bucket_hash #(
        .BUCKETS     (BUCKETS),
        .HASH_OFFSET (HASH_OFFSET),
        .BW          (BW)
    ) u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept),
        .i_key    (i_key),
        .o_done   (w_hash_done),
        .o_bucket (w_hash_bucket)
    );

    assign w_head_we = (r_state == S_CLEAR) ||
                       (r_state == S_DECIDE && r_kind == KIND_INSERT && !w_full);
    assign w_head_wa = (r_state == S_CLEAR) ? r_clr : r_bucket;
    assign w_head_wd = (r_state == S_CLEAR) ? '0 : {1'b1, r_alloc[PW-1:0]};
    assign w_pool_we = (r_state == S_DECIDE) && (r_kind == KIND_INSERT) && !w_full;
    assign w_pool_ra = (r_state == S_DECIDE) ? r_head_rd[PW-1:0] : r_pool_rd[PW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_head_we) begin
            head_mem[w_head_wa] <= w_head_wd;
        end
        r_head_rd <= head_mem[r_bucket];
    end

    always_ff @(posedge i_clk) begin
        if (w_pool_we) begin
            pool_mem[r_alloc[PW-1:0]] <= {r_key, r_head_rd};
        end
        r_pool_rd <= pool_mem[w_pool_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_alloc <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == BW'(BUCKETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (w_hash_done) begin
                        r_state <= S_HEAD;
                    end
                end
                S_HEAD: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (r_kind == KIND_INSERT) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                        if (!w_full) begin
                            r_alloc <= r_alloc + 1'b1;
                        end
                    end else if (!r_head_rd[PW]) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (w_match || !r_pool_rd[PW]) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_kind;
            r_key  <= i_key;
        end
        if (r_state == S_HASH && w_hash_done) begin
            r_bucket <= w_hash_bucket;
        end
        if (r_state == S_DECIDE) begin
            r_found     <= 1'b0;
            r_pool_full <= (r_kind == KIND_INSERT) && w_full;
        end else if (r_state == S_WALK) begin
            r_found     <= w_match;
            r_pool_full <= 1'b0;
        end
    end

    assign o_done      = r_done;
    assign o_found     = r_found;
    assign o_pool_full = r_pool_full;

endmodule
